>>> sv/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

    // fixed field widths of the ports
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SLOT_BITS = 5;
    localparam int OFFSET_BITS = 5;
    localparam int PIXEL_PORT_BITS = 8;
    localparam int CX_BITS = 10;
    localparam int CY_BITS = 12;
    localparam int DESC_BITS = 32;
    localparam int ROW_BITS = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int MAX_ROWS = 4096;
    localparam int WIDTH_FIELD_BITS = 11;
    localparam int COUNT_FIELD_BITS = 6;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEST_COUNT = 2'd2;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // window ages, wide enough for any border in range
    localparam int AGE_BITS = 6;

    typedef struct packed {
        logic [AGE_BITS-1:0] a_col;
        logic [AGE_BITS-1:0] a_row;
        logic [AGE_BITS-1:0] b_col;
        logic [AGE_BITS-1:0] b_row;
    } test_entry_t;

endpackage

>>> sv/pairwise_pixel_test_descriptor_unit.sv
`timescale 1ns / 1ps

// channel  | signals                                   | role
// ---------+-------------------------------------------+--------------------------------
// in       | in_valid/in_ready, kind..pixel            | test load or pixel beat
// out      | out_valid/out_ready, centre_x/y, descr.   | one beat per interior pixel
// cfg      | cfg_write, cfg_index, cfg_data            | register write, no wait
//
// one beat per cycle sustained while in_ready stays high; a pixel result passes
// the line store read, window shift and test compare into the output register
// reset clears counters, pipeline valids and registers to their defaults;
// line store, window and test table hold nothing defined until written
// in_ready drops only while a finished result waits in the output register
// and another result stands behind it

module pairwise_pixel_test_descriptor_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int BORDER = 13,
    parameter int MAX_TESTS = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ppt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ppt_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [ppt_pkg::SLOT_BITS-1:0]         test_slot,
    input  logic signed [ppt_pkg::OFFSET_BITS-1:0] first_dx,
    input  logic signed [ppt_pkg::OFFSET_BITS-1:0] first_dy,
    input  logic signed [ppt_pkg::OFFSET_BITS-1:0] second_dx,
    input  logic signed [ppt_pkg::OFFSET_BITS-1:0] second_dy,
    input  logic [ppt_pkg::PIXEL_PORT_BITS-1:0]   pixel,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ppt_pkg::CX_BITS-1:0]           centre_x,
    output logic [ppt_pkg::CY_BITS-1:0]           centre_y,
    output logic [ppt_pkg::DESC_BITS-1:0]         descriptor
);

    localparam int WIN = 2 * BORDER + 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int TCW = $clog2(MAX_TESTS + 1);
    localparam int TW = (MAX_TESTS > 1) ? $clog2(MAX_TESTS) : 1;
    localparam int RMW = $clog2(WIN);

    // ---------------- configuration registers ----------------
    logic [WW-1:0]                   width_reg, width_next;
    logic [ppt_pkg::HEIGHT_BITS-1:0] height_reg, height_next;
    logic [TCW-1:0]                  tcount_reg, tcount_next;

    logic [ppt_pkg::WIDTH_FIELD_BITS-1:0] cfg_w;
    logic [ppt_pkg::HEIGHT_BITS-1:0]      cfg_h;
    logic [ppt_pkg::COUNT_FIELD_BITS-1:0] cfg_t;

    assign cfg_w = cfg_data[ppt_pkg::WIDTH_FIELD_BITS-1:0];
    assign cfg_h = cfg_data[ppt_pkg::HEIGHT_BITS-1:0];
    assign cfg_t = cfg_data[ppt_pkg::COUNT_FIELD_BITS-1:0];

    // saturate written values into their legal ranges
    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        tcount_next = tcount_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                ppt_pkg::REG_IMAGE_WIDTH:
                begin
                    if (int'(cfg_w) < WIN)
                        width_next = WW'(WIN);
                    else if (int'(cfg_w) > MAX_WIDTH)
                        width_next = WW'(MAX_WIDTH);
                    else
                        width_next = WW'(cfg_w);
                end
                ppt_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (int'(cfg_h) < WIN)
                        height_next = ppt_pkg::HEIGHT_BITS'(WIN);
                    else if (int'(cfg_h) > ppt_pkg::MAX_ROWS)
                        height_next = ppt_pkg::HEIGHT_BITS'(ppt_pkg::MAX_ROWS);
                    else
                        height_next = cfg_h;
                end
                ppt_pkg::REG_TEST_COUNT:
                begin
                    if (cfg_t == '0)
                        tcount_next = TCW'(1);
                    else if (int'(cfg_t) > MAX_TESTS)
                        tcount_next = TCW'(MAX_TESTS);
                    else
                        tcount_next = TCW'(cfg_t);
                end
                default:
                begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WW'(640);
            height_reg <= ppt_pkg::HEIGHT_BITS'(480);
            tcount_reg <= TCW'(MAX_TESTS);
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            tcount_reg <= tcount_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s2_emit_reg;
    logic adv;
    logic in_fire;
    logic pix_fire;

    // the whole pipe moves together; it holds only when a result in s2
    // would need the output register that is still occupied
    assign adv = !(s2_valid_reg && s2_emit_reg && out_valid_reg && !out_ready);
    assign in_ready = adv;
    assign in_fire = in_valid && in_ready;
    assign pix_fire = in_fire && (kind == ppt_pkg::KIND_PIXEL);

    // ---------------- stage 0: counters and offset saturation ----------------
    logic [CW-1:0]                col_reg, col_next;
    logic [ppt_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [RMW-1:0]               rmod_reg, rmod_next;
    logic                         emit0;

    assign emit0 = (int'(col_reg) >= 2 * BORDER) && (int'(row_reg) >= 2 * BORDER);

    // rmod follows the row count modulo the window height
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rmod_next = rmod_reg;
        if (pix_fire)
        begin
            if ((WW'(col_reg) + WW'(1)) >= width_reg)
            begin
                col_next = '0;
                if ((ppt_pkg::HEIGHT_BITS'(row_reg) + ppt_pkg::HEIGHT_BITS'(1)) >= height_reg)
                begin
                    row_next = '0;
                    rmod_next = '0;
                end
                else
                begin
                    row_next = row_reg + ppt_pkg::ROW_BITS'(1);
                    rmod_next = (int'(rmod_reg) == WIN - 1) ? '0 : rmod_reg + RMW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rmod_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            rmod_reg <= rmod_next;
        end
    end

    // offset saturated to the border, then turned into an age in the window
    function automatic logic [ppt_pkg::AGE_BITS-1:0] age_of(
        input logic signed [ppt_pkg::OFFSET_BITS-1:0] off
    );
        logic signed [7:0] s;
        logic signed [7:0] age;
        s = 8'(off);
        if (s > 8'(BORDER))
            s = 8'(BORDER);
        else if (s < -8'(BORDER))
            s = -8'(BORDER);
        age = 8'(BORDER) - s;
        return age[ppt_pkg::AGE_BITS-1:0];
    endfunction

    ppt_pkg::test_entry_t entry0;

    assign entry0.a_col = age_of(first_dx);
    assign entry0.a_row = age_of(first_dy);
    assign entry0.b_col = age_of(second_dx);
    assign entry0.b_row = age_of(second_dy);

    // ---------------- stage 1 registers ----------------
    logic                         s1_kind_reg;
    logic                         s1_emit_reg;
    logic [CW-1:0]                s1_col_reg;
    logic [ppt_pkg::ROW_BITS-1:0] s1_row_reg;
    logic [RMW-1:0]               s1_rmod_reg;
    logic [PIXEL_BITS-1:0]        s1_pix_reg;
    logic [ppt_pkg::SLOT_BITS-1:0] s1_slot_reg;
    ppt_pkg::test_entry_t         s1_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= kind;
            s1_emit_reg <= emit0;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            s1_rmod_reg <= rmod_reg;
            s1_pix_reg <= PIXEL_BITS'(pixel);
            s1_slot_reg <= test_slot;
            s1_entry_reg <= entry0;
        end
    end

    // ---------------- line store ----------------
    // one bank per row slot, the row count modulo the window height picks
    // the bank written; all banks are read at the incoming column
    logic [WIN-1:0][PIXEL_BITS-1:0] bank_rd;
    logic                           s1_pix_go;

    assign s1_pix_go = adv && s1_valid_reg && (s1_kind_reg == ppt_pkg::KIND_PIXEL);

    generate
        for (genvar j = 0; j < WIN; j++)
        begin : g_bank
            logic bank_we;

            assign bank_we = s1_pix_go && (s1_rmod_reg == RMW'(j));

            ppt_line_store #(
                .DEPTH (MAX_WIDTH),
                .WIDTH (PIXEL_BITS)
            ) u_bank (
                .clk     (clk),
                .wr_en   (bank_we),
                .wr_addr (s1_col_reg),
                .wr_data (s1_pix_reg),
                .rd_en   (pix_fire),
                .rd_addr (col_reg),
                .rd_data (bank_rd[j])
            );
        end
    endgenerate

    // ---------------- window: chain of column cells ----------------
    logic [WIN-1:0][PIXEL_BITS-1:0]          new_col;
    logic [WIN-1:0][WIN-1:0][PIXEL_BITS-1:0] window;

    // new column ordered by row age, current pixel in the lowest slot
    generate
        for (genvar k = 0; k < WIN; k++)
        begin : g_rot
            if (k == 0)
            begin : g_now
                assign new_col[k] = s1_pix_reg;
            end
            else
            begin : g_old
                logic [RMW-1:0] src;

                assign src = (s1_rmod_reg >= RMW'(k)) ? (s1_rmod_reg - RMW'(k))
                                                     : (s1_rmod_reg + RMW'(WIN - k));
                assign new_col[k] = bank_rd[src];
            end
        end
    endgenerate

    generate
        for (genvar k = 0; k < WIN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                ppt_column_cell #(
                    .WIN        (WIN),
                    .PIXEL_BITS (PIXEL_BITS)
                ) u_cell (
                    .clk     (clk),
                    .shift   (s1_pix_go),
                    .col_in  (new_col),
                    .col_out (window[k])
                );
            end
            else
            begin : g_body
                ppt_column_cell #(
                    .WIN        (WIN),
                    .PIXEL_BITS (PIXEL_BITS)
                ) u_cell (
                    .clk     (clk),
                    .shift   (s1_pix_go),
                    .col_in  (window[k-1]),
                    .col_out (window[k])
                );
            end
        end
    endgenerate

    // ---------------- test table ----------------
    // a load is written as it leaves stage 1, so the pixel ahead of it
    // still compares with the old entries
    ppt_pkg::test_entry_t test_table [MAX_TESTS];

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && (s1_kind_reg == ppt_pkg::KIND_LOAD)
            && (int'(s1_slot_reg) < MAX_TESTS))
        begin
            test_table[s1_slot_reg[TW-1:0]] <= s1_entry_reg;
        end
    end

    // ---------------- stage 2: compare lanes ----------------
    logic [CW-1:0]                s2_col_reg;
    logic [ppt_pkg::ROW_BITS-1:0] s2_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_emit_reg <= s1_valid_reg && (s1_kind_reg == ppt_pkg::KIND_PIXEL)
                           && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    // first test lands in the top bit of the lane vector
    logic [MAX_TESTS-1:0] lane_bits;

    generate
        for (genvar i = 0; i < MAX_TESTS; i++)
        begin : g_lane
            ppt_test_lane #(
                .WIN        (WIN),
                .PIXEL_BITS (PIXEL_BITS)
            ) u_lane (
                .window (window),
                .entry  (test_table[i]),
                .result (lane_bits[MAX_TESTS-1-i])
            );
        end
    endgenerate

    logic [TCW-1:0]                 drop_bits;
    logic [MAX_TESTS-1:0]           desc_narrow;
    logic [ppt_pkg::DESC_BITS-1:0]  desc_next;
    logic [CW-1:0]                  cx_full;
    logic [ppt_pkg::ROW_BITS-1:0]   cy_full;

    // unused tests fall off the low end
    assign drop_bits = TCW'(MAX_TESTS) - tcount_reg;
    assign desc_narrow = lane_bits >> drop_bits;
    assign desc_next = ppt_pkg::DESC_BITS'(desc_narrow);
    assign cx_full = s2_col_reg - CW'(BORDER);
    assign cy_full = s2_row_reg - ppt_pkg::ROW_BITS'(BORDER);

    // ---------------- output register ----------------
    logic [ppt_pkg::CX_BITS-1:0]   cx_reg;
    logic [ppt_pkg::CY_BITS-1:0]   cy_reg;
    logic [ppt_pkg::DESC_BITS-1:0] desc_reg;
    logic                          out_load;

    assign out_load = adv && s2_valid_reg && s2_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cx_reg <= ppt_pkg::CX_BITS'(cx_full);
            cy_reg <= ppt_pkg::CY_BITS'(cy_full);
            desc_reg <= desc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign centre_x = cx_reg;
    assign centre_y = cy_reg;
    assign descriptor = desc_reg;

`ifndef SYNTHESIS
    // an interior pixel leaving compare always shows up at the output
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("emitting pixel did not reach the output register");

    // a pixel beat always enters stage 1 and reads the line store
    a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire |=> (s1_valid_reg && (s1_kind_reg == ppt_pkg::KIND_PIXEL)))
        else $error("accepted pixel missing from stage 1");

    // input is held back only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && s2_emit_reg && s2_valid_reg))
        else $error("input stalled without a waiting result");
`endif

endmodule

>>> sv/ppt_line_store.sv
`timescale 1ns / 1ps

module ppt_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 208
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ppt_column_cell.sv
`timescale 1ns / 1ps

module ppt_column_cell #(
    parameter int WIN = 27,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                shift,
    input  logic [WIN-1:0][PIXEL_BITS-1:0]      col_in,
    output logic [WIN-1:0][PIXEL_BITS-1:0]      col_out
);

    logic [WIN-1:0][PIXEL_BITS-1:0] col_reg;

    // one window column, handed to the older neighbor on every shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> sv/ppt_test_lane.sv
`timescale 1ns / 1ps

module ppt_test_lane #(
    parameter int WIN = 27,
    parameter int PIXEL_BITS = 8
) (
    input  logic [WIN-1:0][WIN-1:0][PIXEL_BITS-1:0] window,
    input  ppt_pkg::test_entry_t                    entry,
    output logic                                    result
);

    localparam int IW = (WIN > 1) ? $clog2(WIN) : 1;

    logic [PIXEL_BITS-1:0] a_pix;
    logic [PIXEL_BITS-1:0] b_pix;

    assign a_pix = window[entry.a_col[IW-1:0]][entry.a_row[IW-1:0]];
    assign b_pix = window[entry.b_col[IW-1:0]][entry.b_row[IW-1:0]];
    assign result = (a_pix > b_pix);

endmodule

>>> sim/ppt_descriptor_checker.sv
`timescale 1ns / 1ps

module ppt_descriptor_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [ppt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [ppt_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   kind,
    input  logic [ppt_pkg::SLOT_BITS-1:0]          test_slot,
    input  logic [ppt_pkg::OFFSET_BITS-1:0]        first_dx,
    input  logic [ppt_pkg::OFFSET_BITS-1:0]        first_dy,
    input  logic [ppt_pkg::OFFSET_BITS-1:0]        second_dx,
    input  logic [ppt_pkg::OFFSET_BITS-1:0]        second_dy,
    input  logic [ppt_pkg::PIXEL_PORT_BITS-1:0]    pixel,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [ppt_pkg::CX_BITS-1:0]            centre_x,
    input  logic [ppt_pkg::CY_BITS-1:0]            centre_y,
    input  logic [ppt_pkg::DESC_BITS-1:0]          descriptor,
    output int                                     fail_count,
    output int                                     pending
);

    localparam int EDGE_GAP = 13;
    localparam int SPAN = 2 * EDGE_GAP + 1;
    localparam int LINE_LEN = 1024;

    typedef struct {
        logic [ppt_pkg::CX_BITS-1:0]   cx;
        logic [ppt_pkg::CY_BITS-1:0]   cy;
        logic [ppt_pkg::DESC_BITS-1:0] bits;
    } descr_beat_t;

    descr_beat_t descr_fifo[$];
    logic [7:0] line_mem[SPAN][LINE_LEN];
    int a_dx[32], a_dy[32], b_dx[32], b_dy[32];
    int col_cnt, row_cnt, img_w, img_h, n_tests;

    function automatic int sat_offset(logic [ppt_pkg::OFFSET_BITS-1:0] v);
        int s;
        s = v[4] ? int'(v) - 32 : int'(v);
        if (s > EDGE_GAP) s = EDGE_GAP;
        if (s < -EDGE_GAP) s = -EDGE_GAP;
        return s;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int c, r, cx, cy, i, pa, pb;
        logic [ppt_pkg::DESC_BITS-1:0] acc;
        descr_beat_t got, want;
        if (!rst_n)
        begin
            descr_fifo.delete();
            col_cnt = 0;
            row_cnt = 0;
            img_w = 640;
            img_h = 480;
            n_tests = 32;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ppt_pkg::REG_IMAGE_WIDTH:
                        img_w = clamp(int'(cfg_data[10:0]), SPAN, LINE_LEN);
                    ppt_pkg::REG_IMAGE_HEIGHT:
                        img_h = clamp(int'(cfg_data), SPAN, ppt_pkg::MAX_ROWS);
                    ppt_pkg::REG_TEST_COUNT:
                        n_tests = clamp(int'(cfg_data[5:0]), 1, 32);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (kind == ppt_pkg::KIND_LOAD)
                begin
                    a_dx[test_slot] = sat_offset(first_dx);
                    a_dy[test_slot] = sat_offset(first_dy);
                    b_dx[test_slot] = sat_offset(second_dx);
                    b_dy[test_slot] = sat_offset(second_dy);
                end
                else
                begin
                    c = col_cnt;
                    r = row_cnt;
                    line_mem[r % SPAN][c] = pixel;
                    if (c >= 2 * EDGE_GAP && r >= 2 * EDGE_GAP)
                    begin
                        cx = c - EDGE_GAP;
                        cy = r - EDGE_GAP;
                        acc = '0;
                        for (i = 0; i < n_tests; i++)
                        begin
                            pa = line_mem[(cy + a_dy[i]) % SPAN][cx + a_dx[i]];
                            pb = line_mem[(cy + b_dy[i]) % SPAN][cx + b_dx[i]];
                            acc = {acc[ppt_pkg::DESC_BITS-2:0], pa > pb};
                        end
                        want.cx = cx;
                        want.cy = cy;
                        want.bits = acc;
                        descr_fifo.push_back(want);
                    end
                    if (c + 1 >= img_w)
                    begin
                        col_cnt = 0;
                        row_cnt = (r + 1 >= img_h) ? 0 : r + 1;
                    end
                    else
                        col_cnt = c + 1;
                end
            end
            if (out_valid && out_ready)
            begin
                got.cx = centre_x;
                got.cy = centre_y;
                got.bits = descriptor;
                if (descr_fifo.size() == 0)
                begin
                    $error("unexpected descriptor beat at %0d,%0d", got.cx, got.cy);
                    fail_count++;
                end
                else
                begin
                    want = descr_fifo.pop_front();
                    if (got.cx !== want.cx)
                    begin
                        $error("centre_x expected %0d actual %0d", want.cx, got.cx);
                        fail_count++;
                    end
                    if (got.cy !== want.cy)
                    begin
                        $error("centre_y expected %0d actual %0d", want.cy, got.cy);
                        fail_count++;
                    end
                    if (got.bits !== want.bits)
                    begin
                        $error("descriptor expected %h actual %h", want.bits, got.bits);
                        fail_count++;
                    end
                end
            end
            pending = descr_fifo.size();
        end
    end

endmodule

>>> sim/tb_pairwise_pixel_test_descriptor_unit.sv
`timescale 1ns / 1ps

module tb_pairwise_pixel_test_descriptor_unit;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [ppt_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ppt_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic in_valid, in_ready;
    logic kind;
    logic [ppt_pkg::SLOT_BITS-1:0] test_slot;
    logic signed [ppt_pkg::OFFSET_BITS-1:0] first_dx, first_dy, second_dx, second_dy;
    logic [ppt_pkg::PIXEL_PORT_BITS-1:0] pixel;
    logic out_valid, out_ready;
    logic [ppt_pkg::CX_BITS-1:0] centre_x;
    logic [ppt_pkg::CY_BITS-1:0] centre_y;
    logic [ppt_pkg::DESC_BITS-1:0] descriptor;
    int fail_count, pending;

    // sender and receiver each run calm stretches with no gaps
    bit send_calm, recv_calm;
    int send_left, recv_left;
    bit paused_once;

    pairwise_pixel_test_descriptor_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .test_slot(test_slot),
        .first_dx(first_dx), .first_dy(first_dy),
        .second_dx(second_dx), .second_dy(second_dy),
        .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .centre_x(centre_x), .centre_y(centre_y), .descriptor(descriptor)
    );

    ppt_descriptor_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .test_slot(test_slot),
        .first_dx(first_dx), .first_dy(first_dy),
        .second_dx(second_dx), .second_dy(second_dy),
        .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .centre_x(centre_x), .centre_y(centre_y), .descriptor(descriptor),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    // gap drawn per beat, zero inside a calm stretch
    function automatic int draw_gap(ref bit calm, ref int left);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // pixel values lean on the extremes so equal and saturated compares show up
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one input beat, valid held until accepted
    task automatic offer_beat(logic k, logic [4:0] slot, logic [4:0] adx, logic [4:0] ady,
                              logic [4:0] bdx, logic [4:0] bdy, logic [7:0] pix);
        int gap;
        gap = draw_gap(send_calm, send_left);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind = k;
        test_slot = slot;
        first_dx = adx;
        first_dy = ady;
        second_dx = bdx;
        second_dy = bdy;
        pixel = pix;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_random_test(logic [4:0] slot);
        offer_beat(ppt_pkg::KIND_LOAD, slot, 5'($urandom), 5'($urandom), 5'($urandom),
                   5'($urandom), 8'($urandom));
    endtask

    // drain every pending result, then let the pipeline settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [ppt_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [ppt_pkg::CFG_DATA_BITS-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // a whole frame from row 0 so every window is written before it is read
    task automatic send_frame(int w, int h, bit with_pause);
        for (int i = 0; i < w * h; i++)
        begin
            // table rewrites between pixels exercise load ordering
            if ($urandom_range(0, 39) == 0)
                load_random_test(5'($urandom));
            // pause with results in flight, then change the test count
            if (with_pause && !paused_once && i == w * (h - 1) - 2)
            begin
                paused_once = 1'b1;
                wait_idle();
                write_reg(ppt_pkg::REG_TEST_COUNT, 13'($urandom_range(0, 31)));
            end
            offer_beat(ppt_pkg::KIND_PIXEL, 5'($urandom), 5'($urandom), 5'($urandom),
                       5'($urandom), 5'($urandom), pick_pixel());
        end
    endtask

    // receiver: random stall per beat, one long hold-off to back up the input
    initial
    begin
        int stall, taken;
        bit held;
        out_ready = 1'b0;
        taken = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(recv_calm, recv_left);
            if (!held && taken >= 20)
            begin
                held = 1'b1;
                stall = 300;
            end
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        logic [4:0] corner [4];
        corner = '{5'b10000, 5'b01111, 5'b10011, 5'b01101};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = ppt_pkg::REG_IMAGE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = ppt_pkg::KIND_LOAD;
        test_slot = '0;
        first_dx = '0;
        first_dy = '0;
        second_dx = '0;
        second_dy = '0;
        pixel = '0;
        send_left = 0;
        recv_left = 0;
        paused_once = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // frame size with a height not a multiple of the window; count clamps down
        write_reg(ppt_pkg::REG_IMAGE_WIDTH, 13'd31);
        write_reg(ppt_pkg::REG_IMAGE_HEIGHT, 13'd33);
        write_reg(ppt_pkg::REG_TEST_COUNT, 13'h3F);

        // fill the whole table; first slots hit the saturating offsets
        for (int s = 0; s < 32; s++)
        begin
            if (s < 4)
                offer_beat(ppt_pkg::KIND_LOAD, 5'(s), corner[s], corner[3 - s],
                           corner[(s + 1) % 4], corner[(s + 2) % 4], 8'd0);
            else
                load_random_test(5'(s));
        end
        send_frame(31, 33, 1'b1);

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
